// ===== design/btcd_pkg.sv =====
// ----------------------------------------------------------------------------
// btcd_pkg: shared types and constants for the box table block
// Operation, hit and register codes, field widths and the box entry types.
// ----------------------------------------------------------------------------
package btcd_pkg;

  // Table size and slot index width
  localparam int BOX_COUNT = 8;
  localparam int IDX_W     = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1;

  // Field widths
  localparam int POS_W   = 16;
  localparam int EXT_W   = 10;
  localparam int AREA_W  = 4;
  localparam int HLTH_W  = 4;
  localparam int MARG_W  = 8;
  localparam int GROW_W  = 11;   // reach + margin
  localparam int CALC_W  = 18;   // signed width of bound and penetration math
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  // Operation codes
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_COLLIDE = 2'd1;
  localparam logic [1:0] OP_DAMAGE  = 2'd2;

  // Hit codes
  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_HIT  = 2'd1;
  localparam logic [1:0] HIT_DEST = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VHH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEALTH = 2'd2;

  // Register reset values
  localparam logic [EXT_W-1:0]  VHH_RST    = 10'd188;
  localparam logic [MARG_W-1:0] MARGIN_RST = 8'd8;
  localparam logic [HLTH_W-1:0] HEALTH_RST = 4'd3;

  // Geometry of one box
  typedef struct packed {
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic [EXT_W-1:0]        hx;
    logic [EXT_W-1:0]        hz;
  } box_ent_t;

  // Status of one box
  typedef struct packed {
    logic              active;
    logic              destroyed;
    logic [AREA_W-1:0] area;
    logic [HLTH_W-1:0] health;
  } box_stat_t;

  // Verdict of the box unit for the box under test
  typedef struct packed {
    logic                    hit_col;
    logic                    hit_dmg;
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_z;
  } box_res_t;

endpackage

// ===== design/btcd_in_if.sv =====
// ----------------------------------------------------------------------------
// btcd_in_if: operation channel
// Valid/ready channel carrying one operation with its operands.
// ----------------------------------------------------------------------------
interface btcd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            operation;
  logic [2:0]                            entry_index;
  logic signed [btcd_pkg::POS_W-1:0]     pos_x;
  logic signed [btcd_pkg::POS_W-1:0]     pos_y;
  logic signed [btcd_pkg::POS_W-1:0]     pos_z;
  logic [btcd_pkg::EXT_W-1:0]            half_width_x;
  logic [btcd_pkg::EXT_W-1:0]            half_width_z;
  logic [btcd_pkg::AREA_W-1:0]           entry_area;
  logic [btcd_pkg::EXT_W-1:0]            reach;
  logic [btcd_pkg::HLTH_W-1:0]           amount;
  logic [btcd_pkg::AREA_W-1:0]           current_area;

  modport source (
    output valid, operation, entry_index, pos_x, pos_y, pos_z, half_width_x,
           half_width_z, entry_area, reach, amount, current_area,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, pos_x, pos_y, pos_z, half_width_x,
           half_width_z, entry_area, reach, amount, current_area,
    output ready
  );
endinterface

// ===== design/btcd_out_if.sv =====
// ----------------------------------------------------------------------------
// btcd_out_if: result channel
// Valid/ready channel carrying the final position and the hit code.
// ----------------------------------------------------------------------------
interface btcd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [btcd_pkg::POS_W-1:0] new_x;
  logic signed [btcd_pkg::POS_W-1:0] new_z;
  logic [1:0]                        hit_code;

  modport source (output valid, new_x, new_z, hit_code, input ready);
  modport sink   (input valid, new_x, new_z, hit_code, output ready);
endinterface

// ===== design/btcd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// btcd_cfg_if: register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface btcd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [btcd_pkg::CFG_IDX_W-1:0]     index;
  logic [btcd_pkg::CFG_DAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/btcd_box_unit.sv =====
// ----------------------------------------------------------------------------
// btcd_box_unit: shared box test unit
// Two steps per box: a calc cycle registers the widened bounds, the four
// penetrations and the vertical band test; the result is then read out as
// collide/damage verdicts and the pushed-out position.
// ----------------------------------------------------------------------------
module btcd_box_unit (
  input  logic                               clk,
  input  logic                               calc_en,
  input  btcd_pkg::box_ent_t                 ent,
  input  logic                               live,
  input  logic signed [btcd_pkg::POS_W-1:0]  x,
  input  logic signed [btcd_pkg::POS_W-1:0]  y,
  input  logic signed [btcd_pkg::POS_W-1:0]  z,
  input  logic [btcd_pkg::GROW_W-1:0]        grow,
  input  logic [btcd_pkg::EXT_W-1:0]         vhh,
  output btcd_pkg::box_res_t                 res
);

  localparam int W = btcd_pkg::CALC_W;
  localparam logic signed [W-1:0] SAT_MAX = 18'sd32767;
  localparam logic signed [W-1:0] SAT_MIN = -18'sd32768;
  localparam logic signed [W-1:0] ZERO    = '0;

  typedef enum logic [1:0] {DIR_NX, DIR_PX, DIR_NZ, DIR_PZ} dir_t;

  function automatic logic signed [btcd_pkg::POS_W-1:0] sat16(
    input logic signed [W-1:0] v);
    logic signed [btcd_pkg::POS_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[btcd_pkg::POS_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[btcd_pkg::POS_W-1:0];
    end else begin
      r = v[btcd_pkg::POS_W-1:0];
    end
    return r;
  endfunction

  // Operands widened to the calc width
  logic signed [W-1:0] x_e, y_e, z_e, cx_e, cy_e, cz_e, hx_e, hz_e, g_e, v_e;
  assign x_e  = W'(x);
  assign y_e  = W'(y);
  assign z_e  = W'(z);
  assign cx_e = W'(ent.cx);
  assign cy_e = W'(ent.cy);
  assign cz_e = W'(ent.cz);
  assign hx_e = signed'(W'(ent.hx));
  assign hz_e = signed'(W'(ent.hz));
  assign g_e  = signed'(W'(grow));
  assign v_e  = signed'(W'(vhh));

  // Bounds, penetrations and band test
  logic signed [W-1:0] lo_x, hi_x, lo_z, hi_z, pl, pr, pf, pb, dy, neg_v;
  logic                band;
  assign lo_x  = cx_e - hx_e - g_e;
  assign hi_x  = cx_e + hx_e + g_e;
  assign lo_z  = cz_e - hz_e - g_e;
  assign hi_z  = cz_e + hz_e + g_e;
  assign pl    = x_e - cx_e + hx_e + g_e;
  assign pr    = cx_e + hx_e + g_e - x_e;
  assign pf    = z_e - cz_e + hz_e + g_e;
  assign pb    = cz_e + hz_e + g_e - z_e;
  assign dy    = y_e - cy_e;
  assign neg_v = -v_e;
  assign band  = (dy >= neg_v) && (dy <= v_e);

  logic signed [W-1:0] lo_x_r, hi_x_r, lo_z_r, hi_z_r, pl_r, pr_r, pf_r, pb_r;
  logic                band_r, live_r;

  // Calc stage registers
  always_ff @(posedge clk) begin
    if (calc_en) begin
      lo_x_r <= lo_x;
      hi_x_r <= hi_x;
      lo_z_r <= lo_z;
      hi_z_r <= hi_z;
      pl_r   <= pl;
      pr_r   <= pr;
      pf_r   <= pf;
      pb_r   <= pb;
      band_r <= band;
      live_r <= live;
    end
  end

  // Least penetration; ties keep the earlier direction
  logic signed [W-1:0] best;
  dir_t                dir;
  always_comb begin
    best = pl_r;
    dir  = DIR_NX;
    if (pr_r < best) begin
      best = pr_r;
      dir  = DIR_PX;
    end
    if (pf_r < best) begin
      best = pf_r;
      dir  = DIR_NZ;
    end
    if (pb_r < best) begin
      dir  = DIR_PZ;
    end
  end

  // Verdicts and pushed position
  always_comb begin
    res.hit_col = live_r && band_r && (pl_r > ZERO) && (pr_r > ZERO)
                  && (pf_r > ZERO) && (pb_r > ZERO);
    res.hit_dmg = live_r && (pl_r >= ZERO) && (pr_r >= ZERO)
                  && (pf_r >= ZERO) && (pb_r >= ZERO);
    res.new_x   = x;
    res.new_z   = z;
    unique case (dir)
      DIR_NX: res.new_x = sat16(lo_x_r);
      DIR_PX: res.new_x = sat16(hi_x_r);
      DIR_NZ: res.new_z = sat16(lo_z_r);
      DIR_PZ: res.new_z = sat16(hi_z_r);
      default: res.new_x = x;
    endcase
  end

endmodule

// ===== design/box_table_collision_and_damage.sv =====
// ----------------------------------------------------------------------------
// box_table_collision_and_damage: box table with push-out and damage
// Keeps a table of boxes; collide pushes a body out of each live box in
// turn, damage hits the first live box that holds the point.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        operation, operands
//  out_ch    out  valid/ready        new_x, new_z, hit_code
//  cfg_ch    in   valid/ready (=1)   register index, data
//
// Write and unused operations go straight to the finish step, which loads
//   the result register once any held result is taken.
// Collide: every slot passes through the shared box unit, with one calc and
//   one apply step each.
// Damage: slots go through calc and apply up to the first hit or last slot.
// Input ready only while idle; a held result stalls the next finish only.
// Reset idles the sequencer, presets the registers and clears all slot status.
// ----------------------------------------------------------------------------
module box_table_collision_and_damage (
  input  logic        clk,
  input  logic        rst_n,
  btcd_in_if.sink     in_ch,
  btcd_out_if.source  out_ch,
  btcd_cfg_if.sink    cfg_ch
);

  localparam int IW = btcd_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(btcd_pkg::BOX_COUNT - 1);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_APPLY, S_FINISH} state_t;

  state_t                                state_r;
  logic [1:0]                            op_r;
  logic [IW-1:0]                         box_idx_r;
  logic signed [btcd_pkg::POS_W-1:0]     x_r, y_r, z_r;
  logic [btcd_pkg::GROW_W-1:0]           grow_r;
  logic [btcd_pkg::HLTH_W-1:0]           amount_r;
  logic [btcd_pkg::AREA_W-1:0]           area_r;
  logic [1:0]                            code_r;
  logic                                  out_valid_r;
  logic signed [btcd_pkg::POS_W-1:0]     out_x_r, out_z_r;
  logic [1:0]                            out_code_r;

  logic [btcd_pkg::EXT_W-1:0]            vhh_r;
  logic [btcd_pkg::MARG_W-1:0]           margin_r;
  logic [btcd_pkg::HLTH_W-1:0]           full_health_r;

  btcd_pkg::box_ent_t                    ent_r  [btcd_pkg::BOX_COUNT];
  btcd_pkg::box_stat_t                   stat_r [btcd_pkg::BOX_COUNT];

  logic                                  in_xfer, out_xfer, cfg_xfer;
  logic                                  out_load;
  logic                                  wr_slot;
  btcd_pkg::box_stat_t                   cur_stat;
  logic                                  cur_live;
  logic [btcd_pkg::HLTH_W-1:0]           health_nxt;
  logic [btcd_pkg::GROW_W-1:0]           grow_nxt;
  btcd_pkg::box_res_t                    res;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_xfer     = out_valid_r && out_ch.ready;
  assign cfg_xfer     = cfg_ch.valid && cfg_ch.ready;
  assign out_load     = (state_r == S_FINISH) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid    = out_valid_r;
  assign out_ch.new_x    = out_x_r;
  assign out_ch.new_z    = out_z_r;
  assign out_ch.hit_code = out_code_r;

  assign wr_slot = in_xfer && (in_ch.operation == btcd_pkg::OP_WRITE)
                   && (int'(in_ch.entry_index) < btcd_pkg::BOX_COUNT);

  // Slot under test
  assign cur_stat   = stat_r[box_idx_r];
  assign cur_live   = cur_stat.active && !cur_stat.destroyed
                      && (cur_stat.area == area_r);
  assign health_nxt = (cur_stat.health > amount_r) ? cur_stat.health - amount_r
                                                   : '0;
  assign grow_nxt   = (in_ch.operation == btcd_pkg::OP_COLLIDE)
                      ? btcd_pkg::GROW_W'(in_ch.reach) + btcd_pkg::GROW_W'(margin_r)
                      : btcd_pkg::GROW_W'(in_ch.reach);

  btcd_box_unit u_unit (
    .clk     (clk),
    .calc_en (state_r == S_CALC),
    .ent     (ent_r[box_idx_r]),
    .live    (cur_live),
    .x       (x_r),
    .y       (y_r),
    .z       (z_r),
    .grow    (grow_r),
    .vhh     (vhh_r),
    .res     (res)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vhh_r         <= btcd_pkg::VHH_RST;
      margin_r      <= btcd_pkg::MARGIN_RST;
      full_health_r <= btcd_pkg::HEALTH_RST;
    end else if (cfg_xfer) begin
      unique case (cfg_ch.index)
        btcd_pkg::REG_VHH:    vhh_r         <= cfg_ch.data;
        btcd_pkg::REG_MARGIN: margin_r      <= cfg_ch.data[btcd_pkg::MARG_W-1:0];
        btcd_pkg::REG_HEALTH: full_health_r <= cfg_ch.data[btcd_pkg::HLTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Box geometry store, no reset
  always_ff @(posedge clk) begin
    if (wr_slot) begin
      ent_r[IW'(in_ch.entry_index)] <= '{cx: in_ch.pos_x, cy: in_ch.pos_y,
                                         cz: in_ch.pos_z, hx: in_ch.half_width_x,
                                         hz: in_ch.half_width_z};
    end
  end

  // Box status store: armed on write, worn down by damage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < btcd_pkg::BOX_COUNT; i++) begin
        stat_r[i] <= '0;
      end
    end else if (wr_slot) begin
      stat_r[IW'(in_ch.entry_index)] <= '{active: 1'b1, destroyed: 1'b0,
                                          area: in_ch.entry_area,
                                          health: full_health_r};
    end else if (state_r == S_APPLY && op_r == btcd_pkg::OP_DAMAGE && res.hit_dmg) begin
      stat_r[box_idx_r] <= '{active: cur_stat.active,
                             destroyed: (health_nxt == '0),
                             area: cur_stat.area, health: health_nxt};
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      box_idx_r   <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_r      <= in_ch.operation;
            x_r       <= in_ch.pos_x;
            y_r       <= in_ch.pos_y;
            z_r       <= in_ch.pos_z;
            grow_r    <= grow_nxt;
            amount_r  <= in_ch.amount;
            area_r    <= in_ch.current_area;
            code_r    <= btcd_pkg::HIT_NONE;
            box_idx_r <= '0;
            if (in_ch.operation == btcd_pkg::OP_COLLIDE ||
                in_ch.operation == btcd_pkg::OP_DAMAGE) begin
              state_r <= S_CALC;
            end else begin
              state_r <= S_FINISH;
            end
          end
        end
        S_CALC: begin
          state_r <= S_APPLY;
        end
        S_APPLY: begin
          if (op_r == btcd_pkg::OP_COLLIDE) begin
            if (res.hit_col) begin
              x_r <= res.new_x;
              z_r <= res.new_z;
            end
            if (box_idx_r == LAST_IDX) begin
              state_r <= S_FINISH;
            end else begin
              box_idx_r <= box_idx_r + 1'b1;
              state_r   <= S_CALC;
            end
          end else if (res.hit_dmg) begin
            code_r  <= (health_nxt == '0) ? btcd_pkg::HIT_DEST : btcd_pkg::HIT_HIT;
            state_r <= S_FINISH;
          end else if (box_idx_r == LAST_IDX) begin
            state_r <= S_FINISH;
          end else begin
            box_idx_r <= box_idx_r + 1'b1;
            state_r   <= S_CALC;
          end
        end
        S_FINISH: begin
          if (out_load) begin
            out_x_r    <= x_r;
            out_z_r    <= z_r;
            out_code_r <= code_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A destroyed slot has no health left
  a_destroyed_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cur_stat.destroyed |-> (cur_stat.health == '0))
    else $error("destroyed slot with health left");

  // A new result is only ever loaded from the finish step
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FINISH))
    else $error("result loaded outside finish");

  // A table walk starts at slot zero
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_ch.operation == btcd_pkg::OP_COLLIDE ||
                 in_ch.operation == btcd_pkg::OP_DAMAGE))
    |=> (state_r == S_CALC && box_idx_r == '0))
    else $error("table walk did not start at slot zero");

  // Write and unused operations go straight to the finish step
  a_write_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !(in_ch.operation == btcd_pkg::OP_COLLIDE ||
                  in_ch.operation == btcd_pkg::OP_DAMAGE))
    |=> (state_r == S_FINISH && code_r == btcd_pkg::HIT_NONE))
    else $error("non-walk operation did not finish at once");

  // A collide never reports a hit code
  a_collide_code: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && op_r == btcd_pkg::OP_COLLIDE)
    |-> (code_r == btcd_pkg::HIT_NONE))
    else $error("collide carries a hit code");

endmodule
